// ===== design/bsr_pkg.sv =====
// Package: widths, codes, state type and helpers for bankers_safety_and_request.
`timescale 1ns / 1ps
package bsr_pkg;
  localparam int MaxProcs     = 8;
  localparam int MaxResources = 8;
  localparam int ValueWidth   = 16;
  localparam int PW           = 3;  // process index bits
  localparam int RW           = 3;  // resource index bits
  localparam int AW           = PW + RW;
  localparam int Depth        = MaxProcs * MaxResources;

  typedef logic [ValueWidth-1:0] val_t;

  localparam logic [2:0] ACT_LD_MAX   = 3'd0;
  localparam logic [2:0] ACT_LD_ALLOC = 3'd1;
  localparam logic [2:0] ACT_LD_AVAIL = 3'd2;
  localparam logic [2:0] ACT_SAFETY   = 3'd3;
  localparam logic [2:0] ACT_REQ      = 3'd4;

  localparam logic [2:0] ST_LOADED  = 3'd0;
  localparam logic [2:0] ST_SAFE    = 3'd1;
  localparam logic [2:0] ST_UNSAFE  = 3'd2;
  localparam logic [2:0] ST_EXCEEDS = 3'd3;
  localparam logic [2:0] ST_WAIT    = 3'd4;
  localparam logic [2:0] ST_GRANTED = 3'd5;
  localparam logic [2:0] ST_DENIED  = 3'd6;

  localparam logic [3:0] CFG_PROCS = 4'd0;
  localparam logic [3:0] CFG_RES   = 4'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_LOAD, S_RQ_RD, S_RQ_CHK, S_GR_RD, S_GR_WR,
    S_SF_INIT, S_SF_RD, S_SF_CHK, S_SF_ADD, S_SF_EMIT, S_RB_RD, S_RB_WR
  } state_t;

  // clamp a config value to 1..max
  function automatic logic [3:0] clamp_cnt(input logic [3:0] v, input logic [3:0] mx);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) r = 4'd1;
    else if (v > mx) r = mx;
    return r;
  endfunction
endpackage

// ===== design/bsr_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bsr_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/bankers_safety_and_request.sv =====
// Top level: banker's algorithm safety check and request handling over RAM-held state.
// Claims and allocations sit in two 64x16 RAMs (registered read), indexed by
// {proc, res}. After reset a clearing pass over all 64 words zeroes both RAMs; busy
// is high and no word is taken (configuration writes still land). A safety check
// reads each (process, resource) pair through the RAM port, with passes over all
// unfinished processes until a pass finds none that fits or all have finished.
// A final request element adds a read sweep over the resources for the claim test,
// a read/write sweep for the tentative grant, a safety check and, if denied, a
// read/write sweep for the rollback.
// Results appear on out_* for exactly one cycle, flagged by out_valid; the receiver
// cannot stall them. seq_proc is zero except in safe results.
`timescale 1ns / 1ps
module bankers_safety_and_request (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_action,
  input  logic [2:0] in_proc,
  input  logic [2:0] in_res,
  input  logic [15:0] in_amount,
  input  logic       in_final_req,
  output logic       out_valid,
  output logic [2:0] out_status,
  output logic [2:0] out_seq_proc,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic [3:0] cfg_index,
  input  logic [3:0] cfg_wdata
);
  import bsr_pkg::*;

  localparam logic [3:0] MaxP = 4'(MaxProcs);
  localparam logic [3:0] MaxR = 4'(MaxResources);

  state_t state_r, state_nxt;

  logic [3:0] nprocs_r, nres_r;

  // latched input word
  logic [2:0] act_r, act_nxt;
  logic [PW-1:0] proc_r, proc_nxt;
  logic [RW-1:0] res_r, res_nxt;
  val_t amt_r, amt_nxt;

  // small register files (eight entries each, read at loop index)
  val_t avail_r [MaxResources];
  val_t reqb_r  [MaxResources];
  val_t work_r  [MaxResources];
  logic [MaxProcs-1:0] fin_r, fin_nxt;
  logic [PW-1:0] seq_r [MaxProcs];

  logic [PW-1:0] pi_r, pi_nxt;      // process scan index
  logic [RW:0]   ri_r, ri_nxt;      // resource scan index (wide enough for count)
  logic [3:0]    cnt_r, cnt_nxt;    // finished count / emit index
  logic          found_r, found_nxt;
  logic          fits_r, fits_nxt;
  logic          rq_r, rq_nxt;      // safety check belongs to a request
  logic [AW-1:0] clr_r, clr_nxt;

  // outputs
  logic       ov_r, ov_nxt;
  logic [2:0] ost_r, ost_nxt;
  logic [2:0] osp_r, osp_nxt;
  logic       olast_r, olast_nxt;

  // RAM ports
  logic          mx_we, al_we;
  logic [AW-1:0] waddr, raddr;
  val_t          mx_wd, al_wd, mx_rd, al_rd;

  // side-effect strobes for the small files
  logic          av_we, rb_we, rb_clr, wk_init, wk_add, seq_we;
  logic [RW-1:0] av_idx;
  val_t          av_wd;

  logic [3:0] np, nr;
  logic [RW-1:0] rj;
  logic signed [ValueWidth+1:0] need_s;
  logic [ValueWidth:0] wsum;
  logic last_res;

  assign np = clamp_cnt(nprocs_r, MaxP);
  assign nr = clamp_cnt(nres_r, MaxR);
  assign rj = ri_r[RW-1:0];
  assign last_res = ({1'b0, ri_r} + 5'd1) >= {1'b0, nr};
  assign need_s = $signed({2'b00, mx_rd}) - $signed({2'b00, al_rd});
  assign wsum = {1'b0, work_r[rj]} + {1'b0, al_rd};

  bsr_ram #(.Width(ValueWidth), .Depth(Depth)) u_max (
    .clk, .we(mx_we), .waddr, .wdata(mx_wd), .raddr, .rdata(mx_rd));
  bsr_ram #(.Width(ValueWidth), .Depth(Depth)) u_alloc (
    .clk, .we(al_we), .waddr, .wdata(al_wd), .raddr, .rdata(al_rd));

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_seq_proc = osp_r;
  assign out_last = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      nprocs_r <= MaxP;
      nres_r <= MaxR;
      clr_r <= '0;
      ov_r <= 1'b0;
      fin_r <= '0;
      for (int k = 0; k < MaxResources; k++) begin
        avail_r[k] <= '0;
        reqb_r[k] <= '0;
        work_r[k] <= '0;
      end
      for (int k = 0; k < MaxProcs; k++) seq_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      ov_r <= ov_nxt;
      fin_r <= fin_nxt;
      if (cfg_we && cfg_index == CFG_PROCS) nprocs_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_RES) nres_r <= cfg_wdata;
      if (av_we) avail_r[av_idx] <= av_wd;
      if (rb_clr) begin
        for (int k = 0; k < MaxResources; k++) reqb_r[k] <= '0;
      end else if (rb_we) reqb_r[res_r] <= amt_r;
      if (wk_init) begin
        for (int k = 0; k < MaxResources; k++)
          work_r[k] <= (k < int'(nr)) ? avail_r[k] : '0;
      end else if (wk_add) begin
        work_r[rj] <= wsum[ValueWidth] ? '1 : wsum[ValueWidth-1:0];
      end
      if (seq_we) seq_r[cnt_r[PW-1:0]] <= pi_r;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;  proc_r <= proc_nxt;  res_r <= res_nxt;  amt_r <= amt_nxt;
    pi_r <= pi_nxt;  ri_r <= ri_nxt;  cnt_r <= cnt_nxt;  found_r <= found_nxt;
    fits_r <= fits_nxt;  rq_r <= rq_nxt;
    ost_r <= ost_nxt;  osp_r <= osp_nxt;  olast_r <= olast_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    act_nxt = act_r;  proc_nxt = proc_r;  res_nxt = res_r;  amt_nxt = amt_r;
    pi_nxt = pi_r;  ri_nxt = ri_r;  cnt_nxt = cnt_r;  found_nxt = found_r;
    fits_nxt = fits_r;  rq_nxt = rq_r;  clr_nxt = clr_r;  fin_nxt = fin_r;
    ov_nxt = 1'b0;  ost_nxt = ST_LOADED;  osp_nxt = '0;  olast_nxt = 1'b1;
    mx_we = 1'b0;  al_we = 1'b0;  mx_wd = amt_r;  al_wd = amt_r;
    waddr = {proc_r, res_r};
    raddr = {proc_r, rj};
    av_we = 1'b0;  av_idx = res_r;  av_wd = amt_r;
    rb_we = 1'b0;  rb_clr = 1'b0;  wk_init = 1'b0;  wk_add = 1'b0;  seq_we = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mx_we = 1'b1;  al_we = 1'b1;  mx_wd = '0;  al_wd = '0;  waddr = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(Depth - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          act_nxt = in_action;  proc_nxt = in_proc;  res_nxt = in_res;
          amt_nxt = in_amount;
          if (in_action == ACT_SAFETY) begin
            rq_nxt = 1'b0;  state_nxt = S_SF_INIT;
          end else if (in_action == ACT_REQ && in_final_req) begin
            state_nxt = S_RQ_RD;  ri_nxt = '0;
          end else if (in_action <= ACT_REQ) begin
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        unique case (act_r)
          ACT_LD_MAX:   mx_we = 1'b1;
          ACT_LD_ALLOC: al_we = 1'b1;
          ACT_LD_AVAIL: av_we = 1'b1;
          default:      rb_we = 1'b1;
        endcase
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      // final request element: store it, then claim test over resources
      S_RQ_RD: begin
        if (ri_r == '0) rb_we = 1'b1;
        if ({1'b0, proc_r} >= np) begin
          ov_nxt = 1'b1;  ost_nxt = ST_EXCEEDS;  rb_clr = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RQ_CHK;
        end
      end
      S_RQ_CHK: begin
        if ($signed({2'b00, reqb_r[rj]}) > need_s) begin
          ov_nxt = 1'b1;  ost_nxt = ST_EXCEEDS;  rb_clr = 1'b1;
          state_nxt = S_IDLE;
        end else if (last_res) begin
          ri_nxt = '0;
          state_nxt = S_GR_RD;
          for (int k = 0; k < MaxResources; k++)
            if (k < int'(nr) && reqb_r[k] > avail_r[k]) begin
              ov_nxt = 1'b1;  ost_nxt = ST_WAIT;  rb_clr = 1'b1;
              state_nxt = S_IDLE;
            end
        end else begin
          ri_nxt = ri_r + 4'd1;
          state_nxt = S_RQ_RD;
        end
      end
      S_GR_RD: state_nxt = S_GR_WR;
      S_GR_WR: begin
        al_we = 1'b1;  waddr = {proc_r, rj};  al_wd = al_rd + reqb_r[rj];
        av_we = 1'b1;  av_idx = rj;  av_wd = avail_r[rj] - reqb_r[rj];
        if (last_res) begin
          rq_nxt = 1'b1;  state_nxt = S_SF_INIT;
        end else begin
          ri_nxt = ri_r + 4'd1;  state_nxt = S_GR_RD;
        end
      end
      S_SF_INIT: begin
        wk_init = 1'b1;  fin_nxt = '0;  cnt_nxt = '0;  pi_nxt = '0;  ri_nxt = '0;
        found_nxt = 1'b0;  fits_nxt = 1'b1;
        state_nxt = S_SF_RD;
      end
      // issue read for (pi, ri); skip finished processes
      S_SF_RD: begin
        raddr = {pi_r, rj};
        if (fin_r[pi_r]) begin
          if ({1'b0, pi_r} + 4'd1 >= np) begin
            pi_nxt = '0;
            if (!found_r) begin
              state_nxt = rq_r ? S_RB_RD : S_SF_EMIT;
              ri_nxt = '0;
            end
            found_nxt = 1'b0;
          end else pi_nxt = pi_r + PW'(1);
        end else state_nxt = S_SF_CHK;
      end
      S_SF_CHK: begin
        raddr = {pi_r, rj};
        if (need_s > $signed({2'b00, work_r[rj]})) begin
          ri_nxt = '0;
          state_nxt = S_SF_RD;
          if ({1'b0, pi_r} + 4'd1 >= np) begin
            pi_nxt = '0;  found_nxt = 1'b0;
            if (!found_r) begin
              state_nxt = rq_r ? S_RB_RD : S_SF_EMIT;
            end
          end else pi_nxt = pi_r + PW'(1);
        end else if (last_res) begin
          ri_nxt = '0;  state_nxt = S_SF_ADD;
          seq_we = 1'b1;  fin_nxt[pi_r] = 1'b1;  cnt_nxt = cnt_r + 4'd1;
        end else begin
          ri_nxt = ri_r + 4'd1;  state_nxt = S_SF_RD;
        end
      end
      // add allocation row into work, one resource at a time: issue the read, then add
      S_SF_ADD: begin
        raddr = {pi_r, rj};
        if (fits_r) begin
          fits_nxt = 1'b0;  // read issued
        end else begin
          wk_add = 1'b1;  fits_nxt = 1'b1;
          if (last_res) begin
            ri_nxt = '0;  found_nxt = 1'b1;  state_nxt = S_SF_RD;
            if (cnt_r >= np) begin
              cnt_nxt = '0;
              state_nxt = rq_r ? S_IDLE : S_SF_EMIT;
              if (rq_r) begin
                ov_nxt = 1'b1;  ost_nxt = ST_GRANTED;  rb_clr = 1'b1;
              end
            end else if ({1'b0, pi_r} + 4'd1 >= np) begin
              pi_nxt = '0;  found_nxt = 1'b0;
            end else pi_nxt = pi_r + PW'(1);
          end else ri_nxt = ri_r + 4'd1;
        end
      end
      S_SF_EMIT: begin
        ov_nxt = 1'b1;
        if (cnt_r < np && fin_r == '1 >> (MaxProcs - int'(np)) && cnt_r != 4'd15) begin
          ost_nxt = ST_SAFE;  osp_nxt = seq_r[cnt_r[PW-1:0]];
          olast_nxt = (cnt_r + 4'd1) >= np;
          cnt_nxt = cnt_r + 4'd1;
          if ((cnt_r + 4'd1) >= np) state_nxt = S_IDLE;
        end else begin
          ost_nxt = ST_UNSAFE;  state_nxt = S_IDLE;
        end
      end
      S_RB_RD: begin
        raddr = {proc_r, rj};
        state_nxt = S_RB_WR;
      end
      S_RB_WR: begin
        al_we = 1'b1;  waddr = {proc_r, rj};  al_wd = al_rd - reqb_r[rj];
        av_we = 1'b1;  av_idx = rj;  av_wd = avail_r[rj] + reqb_r[rj];
        if (last_res) begin
          ov_nxt = 1'b1;  ost_nxt = ST_DENIED;  rb_clr = 1'b1;  state_nxt = S_IDLE;
        end else begin
          ri_nxt = ri_r + 4'd1;  state_nxt = S_RB_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== sim/bsr_checker.sv =====
// Checker: predicts banker's block results from accepted words and compares them.
`timescale 1ns / 1ps
module bsr_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_action,
  input  logic [2:0]  in_proc,
  input  logic [2:0]  in_res,
  input  logic [15:0] in_amount,
  input  logic        in_final_req,
  input  logic        out_valid,
  input  logic [2:0]  out_status,
  input  logic [2:0]  out_seq_proc,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [3:0]  cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  import bsr_pkg::*;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] seq_proc;
    logic       last;
  } verdict_t;

  val_t       claim_m [Depth];
  val_t       alloc_m [Depth];
  val_t       avail_m [MaxResources];
  val_t       req_m   [MaxResources];
  logic [2:0] order_m [MaxProcs];
  logic [3:0] procs_r, res_r;
  verdict_t   verdicts_q[$];

  assign pending = verdicts_q.size();

  function automatic int procs_eff();
    return (procs_r == 0) ? 1 : (procs_r > MaxProcs) ? MaxProcs : procs_r;
  endfunction

  function automatic int res_eff();
    return (res_r == 0) ? 1 : (res_r > MaxResources) ? MaxResources : res_r;
  endfunction

  function automatic longint need_at(int p, int r);
    return longint'(claim_m[p*MaxResources+r]) - longint'(alloc_m[p*MaxResources+r]);
  endfunction

  // Returns number of processes in the safe order, 0 if unsafe.
  function automatic int run_safety();
    int n, m, cnt;
    bit found, fits;
    bit done[MaxProcs];
    longint wk[MaxResources];
    longint s;
    n = procs_eff();
    m = res_eff();
    cnt = 0;
    for (int j = 0; j < MaxResources; j++) wk[j] = (j < m) ? avail_m[j] : 0;
    for (int i = 0; i < MaxProcs; i++) begin
      done[i] = 0;
      order_m[i] = 0;
    end
    while (cnt < n) begin
      found = 0;
      for (int i = 0; i < n; i++) begin
        if (done[i]) continue;
        fits = 1;
        for (int j = 0; j < m; j++)
          if (need_at(i, j) > wk[j]) fits = 0;
        if (fits) begin
          for (int j = 0; j < m; j++) begin
            s = wk[j] + alloc_m[i*MaxResources+j];
            wk[j] = (s > 65535) ? 65535 : s;
          end
          done[i] = 1;
          order_m[cnt] = 3'(i);
          cnt++;
          found = 1;
        end
      end
      if (!found) return 0;
    end
    return n;
  endfunction

  function automatic void push(logic [2:0] st, logic [2:0] sp, logic lst);
    verdict_t v;
    v.status = st;
    v.seq_proc = sp;
    v.last = lst;
    verdicts_q.push_back(v);
  endfunction

  function automatic void settle_request(int p);
    logic [2:0] st;
    int m;
    m = res_eff();
    st = ST_LOADED;
    if (p >= procs_eff()) st = ST_EXCEEDS;
    else begin
      for (int j = 0; j < m; j++)
        if (st == ST_LOADED && longint'(req_m[j]) > need_at(p, j)) st = ST_EXCEEDS;
      for (int j = 0; j < m; j++)
        if (st == ST_LOADED && req_m[j] > avail_m[j]) st = ST_WAIT;
      if (st == ST_LOADED) begin
        for (int j = 0; j < m; j++) begin
          avail_m[j] = avail_m[j] - req_m[j];
          alloc_m[p*MaxResources+j] = alloc_m[p*MaxResources+j] + req_m[j];
        end
        if (run_safety() != 0) st = ST_GRANTED;
        else begin
          for (int j = 0; j < m; j++) begin
            avail_m[j] = avail_m[j] + req_m[j];
            alloc_m[p*MaxResources+j] = alloc_m[p*MaxResources+j] - req_m[j];
          end
          st = ST_DENIED;
        end
      end
    end
    for (int j = 0; j < MaxResources; j++) req_m[j] = '0;
    push(st, 3'd0, 1'b1);
  endfunction

  function automatic void accept_word();
    int k;
    case (in_action)
      ACT_LD_MAX: begin
        claim_m[{in_proc, in_res}] = in_amount;
        push(ST_LOADED, 3'd0, 1'b1);
      end
      ACT_LD_ALLOC: begin
        alloc_m[{in_proc, in_res}] = in_amount;
        push(ST_LOADED, 3'd0, 1'b1);
      end
      ACT_LD_AVAIL: begin
        avail_m[in_res] = in_amount;
        push(ST_LOADED, 3'd0, 1'b1);
      end
      ACT_SAFETY: begin
        k = run_safety();
        if (k == 0) push(ST_UNSAFE, 3'd0, 1'b1);
        else for (int i = 0; i < k; i++) push(ST_SAFE, order_m[i], i == k - 1);
      end
      ACT_REQ: begin
        req_m[in_res] = in_amount;
        if (!in_final_req) push(ST_LOADED, 3'd0, 1'b1);
        else settle_request(int'(in_proc));
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst_n) begin
      for (int i = 0; i < Depth; i++) begin
        claim_m[i] = '0;
        alloc_m[i] = '0;
      end
      for (int j = 0; j < MaxResources; j++) begin
        avail_m[j] = '0;
        req_m[j] = '0;
      end
      procs_r <= 4'd8;
      res_r <= 4'd8;
      fail_count <= 0;
      results_seen <= 0;
      verdicts_q.delete();
    end else begin
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (verdicts_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d seq=%0d last=%0d",
                   $time, out_status, out_seq_proc, out_last);
          fail_count <= fail_count + 1;
        end else begin
          exp_v = verdicts_q.pop_front();
          if (exp_v != {out_status, out_seq_proc, out_last}) begin
            $display("%0t: expected status=%0d seq=%0d last=%0d, got %0d %0d %0d", $time,
                     exp_v.status, exp_v.seq_proc, exp_v.last,
                     out_status, out_seq_proc, out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      // register writes land after this edge's accepted word is predicted
      if (start && !busy) accept_word();
      if (cfg_we) begin
        if (cfg_index == CFG_PROCS) procs_r <= cfg_wdata;
        else if (cfg_index == CFG_RES) res_r <= cfg_wdata;
      end
    end
  end
endmodule

// ===== sim/bankers_safety_and_request_tb.sv =====
// Testbench top: stimulus, configuration phases and verdict for the banker's block.
`timescale 1ns / 1ps
module bankers_safety_and_request_tb;
  import bsr_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  in_action = '0;
  logic [2:0]  in_proc = '0;
  logic [2:0]  in_res = '0;
  logic [15:0] in_amount = '0;
  logic        in_final_req = 0;
  logic        out_valid;
  logic [2:0]  out_status, out_seq_proc;
  logic        out_last;
  logic        cfg_we = 0;
  logic [3:0]  cfg_index = '0;
  logic [3:0]  cfg_wdata = '0;
  int          fail_count, pending, results_seen;
  int          idle_pct;  // chance in percent that the sender skips a cycle
  int          words_sent;

  always #5 clk = ~clk;

  bankers_safety_and_request uut (.*);
  bsr_checker chk (.*);

  // Hold one word on the inputs until it is taken, idling beforehand at random.
  // busy is stable at the falling edge, so it tells whether the next rising edge takes it.
  task automatic send_word(logic [2:0] act, logic [2:0] p, logic [2:0] r,
                           logic [15:0] amt, logic fin);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_action <= act;
    in_proc <= p;
    in_res <= r;
    in_amount <= amt;
    in_final_req <= fin;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
    start = 1'b0;
    words_sent++;
  endtask

  // Registers change only with nothing in flight; the pause covers ignored words.
  task automatic write_reg(logic [3:0] idx, logic [3:0] val);
    while (pending != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Loads a coherent, mostly-safe system: claims, allocations not above them, spare units.
  task automatic load_system(int n, int m, int scale);
    logic [15:0] cl, al;
    for (int p = 0; p < n; p++)
      for (int r = 0; r < m; r++) begin
        cl = 16'($urandom_range(scale));
        al = 16'($urandom_range(cl));
        send_word(ACT_LD_MAX, 3'(p), 3'(r), cl, 1'b0);
        send_word(ACT_LD_ALLOC, 3'(p), 3'(r), al, 1'b0);
      end
    for (int r = 0; r < m; r++)
      send_word(ACT_LD_AVAIL, 3'd0, 3'(r), 16'($urandom_range(scale)), 1'b0);
  endtask

  // Request vector for one process: random elements, last one flagged.
  task automatic request_vec(int p, int m, int scale);
    int cnt;
    cnt = $urandom_range(m);
    for (int r = 0; r < cnt; r++)
      send_word(ACT_REQ, 3'(p), 3'(r), 16'($urandom_range(scale)), 1'b0);
    send_word(ACT_REQ, 3'(p), 3'($urandom_range(m - 1)), 16'($urandom_range(scale)), 1'b1);
  endtask

  task automatic random_phase(int words, int n, int m);
    int scale;
    int stop_at;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      scale = ($urandom_range(3) == 0) ? 65535 : 7;
      case ($urandom_range(9))
        0: load_system(n, m, scale);
        1, 2, 3: send_word(ACT_SAFETY, 3'($urandom), 3'($urandom), 16'($urandom),
                           1'($urandom));
        4, 5, 6: request_vec(int'($urandom_range(n)), m, scale);
        // noise: any field values, unused action codes included
        default: send_word(3'($urandom), 3'($urandom), 3'($urandom), 16'($urandom),
                           1'($urandom));
      endcase
    end
  endtask

  initial begin
    int wait_cycles;
    idle_pct = 0;
    words_sent = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: safety on empty store, extremes, every action and corner
    send_word(ACT_SAFETY, 3'd0, 3'd0, 16'd0, 1'b0);
    send_word(ACT_REQ, 3'd0, 3'd0, 16'd0, 1'b1);           // all-zero request
    send_word(ACT_LD_MAX, 3'd7, 3'd7, 16'hFFFF, 1'b0);
    send_word(ACT_LD_ALLOC, 3'd7, 3'd7, 16'hFFFF, 1'b0);
    send_word(ACT_LD_AVAIL, 3'd0, 3'd7, 16'hFFFF, 1'b0);
    send_word(ACT_LD_ALLOC, 3'd6, 3'd7, 16'hFFFF, 1'b0);   // negative need, work saturation
    send_word(ACT_SAFETY, 3'd0, 3'd0, 16'd0, 1'b0);
    send_word(ACT_REQ, 3'd6, 3'd7, 16'd1, 1'b1);           // exceeds claim via negative need
    send_word(ACT_LD_ALLOC, 3'd6, 3'd7, 16'd0, 1'b0);
    send_word(ACT_LD_MAX, 3'd2, 3'd0, 16'd5, 1'b0);
    send_word(ACT_REQ, 3'd2, 3'd0, 16'd3, 1'b1);           // must wait (available 0)
    send_word(ACT_LD_AVAIL, 3'd0, 3'd0, 16'd4, 1'b0);
    send_word(ACT_REQ, 3'd2, 3'd0, 16'd3, 1'b1);           // denied: unsafe after the tentative grant
    send_word(ACT_REQ, 3'd2, 3'd0, 16'd2, 1'b1);           // denied: unsafe after the tentative grant
    send_word(ACT_LD_MAX, 3'd1, 3'd1, 16'd9, 1'b0);
    send_word(ACT_REQ, 3'd1, 3'd3, 16'd0, 1'b0);           // partial element then final
    send_word(ACT_REQ, 3'd1, 3'd1, 16'd0, 1'b1);
    send_word(3'd5, 3'd0, 3'd0, 16'd0, 1'b0);              // ignored codes
    send_word(3'd7, 3'd7, 3'd7, 16'hFFFF, 1'b1);
    send_word(ACT_SAFETY, 3'd0, 3'd0, 16'd0, 1'b0);

    write_reg(CFG_PROCS, 4'd0);                            // acts as 1
    write_reg(CFG_RES, 4'd15);                             // acts as max
    send_word(ACT_REQ, 3'd3, 3'd0, 16'd0, 1'b1);           // process out of range
    send_word(ACT_SAFETY, 3'd0, 3'd0, 16'd0, 1'b0);

    // random phases over several shapes
    idle_pct = 31;
    write_reg(CFG_PROCS, 4'd3);
    write_reg(CFG_RES, 4'd2);
    random_phase(70, 3, 2);
    idle_pct = 87;
    write_reg(CFG_PROCS, 4'd8);
    write_reg(CFG_RES, 4'd1);
    random_phase(40, 8, 1);
    idle_pct = 0;
    write_reg(CFG_PROCS, 4'd4);
    write_reg(CFG_RES, 4'd8);
    random_phase(40, 4, 8);
    write_reg(CFG_PROCS, 4'd1);
    write_reg(CFG_RES, 4'd0);
    random_phase(20, 1, 1);
    write_reg(CFG_PROCS, 4'd15);
    write_reg(CFG_RES, 4'd3);
    random_phase(30, 8, 3);

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (1000) @(negedge clk);
    $display("Sent %0d words over seven register settings; %0d results checked.",
             words_sent, results_seen);
    if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #60ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== bankers_safety_and_request.f =====
design/bsr_pkg.sv
design/bsr_ram.sv
design/bankers_safety_and_request.sv
sim/bsr_checker.sv
sim/bankers_safety_and_request_tb.sv
